### hw/rtl/brb_pkg.sv
// Shared types and constants for the byte ring buffer.
// No dependencies; used by brb_ctrl, brb_datapath and byte_ring_buffer.
`default_nettype none

package brb_pkg;

    localparam int BRB_DEPTH     = 4096;
    localparam int BRB_MAX_BURST = 64;

    localparam int OP_W     = 2;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 7;
    localparam int CNT_W    = 7;
    localparam int STAT_W   = 13;
    localparam int CFG_W    = 13;
    localparam int ADDR_W   = 3;
    localparam int APB_W    = 32;

    // word index of the capacity register (paddr[2])
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [1:0] {
        OP_WRITE   = 2'd0,
        OP_READ    = 2'd1,
        OP_PEEK    = 2'd2,
        OP_DISCARD = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_STAT,
        ST_SINGLE,
        ST_BURST
    } state_t;

    typedef struct packed {
        logic latch;   // capture the accepted word
        logic exec;    // apply the item to pointers, level and store
        logic stat;    // snapshot status after the item
        logic single;  // load a status-only result
        logic issue;   // read one burst byte from the store
    } cmd_t;

    typedef struct packed {
        logic burst;      // item emits bytes
        logic rem_one;    // one burst byte left to issue
        logic can_issue;  // read-data stage free or draining
        logic out_free;   // output register free or draining
        logic pend;       // read-data stage holds a byte
    } sts_t;

endpackage

`default_nettype wire

### hw/rtl/byte_ring_buffer.sv
// Byte ring buffer: circular byte FIFO with a programmable active capacity.
// Items enter on the s_* stream with op in s_tuser: write one byte, read and
// consume up to length bytes, peek without consuming, or discard. Results leave
// on the m_* stream, one word per delivered byte (m_tuser = 1) or a single
// status word (m_tuser = 0); m_tlast marks the final word of an item. Every
// word carries count, fill level, free space and both contiguous run lengths
// as they stand after the item.
// Timing: one item at a time. After acceptance an item runs through the states
// EXEC and STAT, then SINGLE, which loads the status word into the output
// register once it is free, or BURST, which issues one store read per cycle
// while the read-data stage is free or draining. Each byte passes the read-data
// stage and the output register; the next item is taken once the last byte has
// left the read-data stage. The single read port of the store paces bursts.
// A stalled receiver holds the output register and the read-data stage; burst
// reads pause until a word leaves. Reset empties the FIFO and sets capacity to
// DEPTH; writing the capacity register also empties it. Configure while idle.
`default_nettype none

module byte_ring_buffer
#(
    parameter int DEPTH     = brb_pkg::BRB_DEPTH,
    parameter int MAX_BURST = brb_pkg::BRB_MAX_BURST
)
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic [15:0]                  s_tdata,  // data_in[7:0], length[14:8]
    input  wire logic [brb_pkg::OP_W-1:0]     s_tuser,  // op
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic [71:0]                       m_tdata,  // data_out, count, fill_level,
                                                        // free_space, read_run, write_run
    output logic                              m_tlast,
    output logic                              m_tuser,  // byte_valid
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [brb_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [brb_pkg::APB_W-1:0]    pwdata,
    output logic [brb_pkg::APB_W-1:0]         prdata,
    output logic                              pready
);

    brb_pkg::cmd_t cmd;
    brb_pkg::sts_t sts;

    logic                           cfg_wr;
    logic [brb_pkg::CFG_W-1:0]      cap;
    logic [brb_pkg::BYTE_W-1:0]     out_data;
    logic [brb_pkg::CNT_W-1:0]      out_count;
    logic [brb_pkg::STAT_W-1:0]     out_fill;
    logic [brb_pkg::STAT_W-1:0]     out_free;
    logic [brb_pkg::STAT_W-1:0]     out_rrun;
    logic [brb_pkg::STAT_W-1:0]     out_wrun;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == brb_pkg::REG_CAPACITY);
    assign prdata = (paddr[2] == brb_pkg::REG_CAPACITY)
                    ? brb_pkg::APB_W'(cap) : '0;

    brb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    brb_datapath
    #(
        .DEPTH     (DEPTH),
        .MAX_BURST (MAX_BURST)
    )
    u_datapath
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .sts            (sts),
        .item_op        (brb_pkg::op_t'(s_tuser)),
        .item_data      (s_tdata[7:0]),
        .item_len       (s_tdata[14:8]),
        .cfg_wr         (cfg_wr),
        .cfg_data       (pwdata[brb_pkg::CFG_W-1:0]),
        .cap            (cap),
        .out_ready      (m_tready),
        .out_valid      (m_tvalid),
        .out_data       (out_data),
        .out_byte_valid (m_tuser),
        .out_last       (m_tlast),
        .out_count      (out_count),
        .out_fill       (out_fill),
        .out_free       (out_free),
        .out_rrun       (out_rrun),
        .out_wrun       (out_wrun)
    );

    assign m_tdata = {5'b0, out_wrun, out_rrun, out_free, out_fill, out_count, out_data};

    // status-only words always close their item
    a_status_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> m_tlast)
        else $error("status word without last mark");

    // one item in flight: no accept right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second item accepted while busy");

    // fill plus free space never exceeds the store
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((32'(out_fill) + 32'(out_free)) <= 32'(DEPTH)))
        else $error("fill level and free space exceed depth");

    // no new item is latched while a burst byte is still in the read-data stage
    a_burst_drained: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.latch |-> !sts.pend)
        else $error("new item taken with burst byte pending");

endmodule

`default_nettype wire

### hw/rtl/brb_ctrl.sv
// Sequencer for the byte ring buffer: one item at a time.
// Depends on brb_pkg (state_t, cmd_t, sts_t).
`default_nettype none

module brb_ctrl
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          s_tvalid,
    output logic               s_tready,
    input  wire brb_pkg::sts_t sts,
    output brb_pkg::cmd_t      cmd
);

    brb_pkg::state_t state_reg;
    brb_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= brb_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            brb_pkg::ST_IDLE:
            begin
                // previous burst must have left the read-data stage
                s_tready = !sts.pend;
                if (s_tvalid && !sts.pend)
                begin
                    cmd.latch  = 1'b1;
                    state_next = brb_pkg::ST_EXEC;
                end
            end
            brb_pkg::ST_EXEC:
            begin
                cmd.exec   = 1'b1;
                state_next = brb_pkg::ST_STAT;
            end
            brb_pkg::ST_STAT:
            begin
                cmd.stat   = 1'b1;
                state_next = sts.burst ? brb_pkg::ST_BURST : brb_pkg::ST_SINGLE;
            end
            brb_pkg::ST_SINGLE:
            begin
                if (sts.out_free)
                begin
                    cmd.single = 1'b1;
                    state_next = brb_pkg::ST_IDLE;
                end
            end
            brb_pkg::ST_BURST:
            begin
                if (sts.can_issue)
                begin
                    cmd.issue = 1'b1;
                    if (sts.rem_one)
                    begin
                        state_next = brb_pkg::ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = brb_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/brb_datapath.sv
// Datapath of the byte ring buffer: store, pointers, level, capacity,
// burst read stage and output register. Depends on brb_pkg.
`default_nettype none

module brb_datapath
#(
    parameter int DEPTH     = brb_pkg::BRB_DEPTH,
    parameter int MAX_BURST = brb_pkg::BRB_MAX_BURST
)
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire brb_pkg::cmd_t                 cmd,
    output brb_pkg::sts_t                      sts,
    input  wire brb_pkg::op_t                  item_op,
    input  wire logic [brb_pkg::BYTE_W-1:0]    item_data,
    input  wire logic [brb_pkg::LEN_W-1:0]     item_len,
    input  wire logic                          cfg_wr,
    input  wire logic [brb_pkg::CFG_W-1:0]     cfg_data,
    output logic [brb_pkg::CFG_W-1:0]          cap,
    input  wire logic                          out_ready,
    output logic                               out_valid,
    output logic [brb_pkg::BYTE_W-1:0]         out_data,
    output logic                               out_byte_valid,
    output logic                               out_last,
    output logic [brb_pkg::CNT_W-1:0]          out_count,
    output logic [brb_pkg::STAT_W-1:0]         out_fill,
    output logic [brb_pkg::STAT_W-1:0]         out_free,
    output logic [brb_pkg::STAT_W-1:0]         out_rrun,
    output logic [brb_pkg::STAT_W-1:0]         out_wrun
);

    localparam int PW = $clog2(DEPTH);
    localparam int LW = $clog2(DEPTH + 1);
    localparam int SW = LW + 1;
    localparam int BW = brb_pkg::BYTE_W;
    localparam int CW = brb_pkg::CNT_W;
    localparam int TW = brb_pkg::STAT_W;

    logic [BW-1:0]  mem [DEPTH];

    brb_pkg::op_t        op_reg;
    logic [BW-1:0]       din_reg;
    logic [brb_pkg::LEN_W-1:0] len_reg;

    logic [brb_pkg::CFG_W-1:0] cap_reg;
    logic [LW-1:0]  capeff_reg;
    logic [PW-1:0]  wp_reg;
    logic [PW-1:0]  rp_reg;
    logic [LW-1:0]  level_reg;

    logic           burst_reg;
    logic [PW-1:0]  bpos_reg;
    logic [CW-1:0]  rem_reg;
    logic [CW-1:0]  cnt_reg;

    logic [LW-1:0]  fill_st_reg;
    logic [LW-1:0]  free_st_reg;
    logic [LW-1:0]  rrun_st_reg;
    logic [LW-1:0]  wrun_st_reg;

    logic [BW-1:0]  rd_data_reg;
    logic           pend_reg;
    logic           pend_last_reg;

    logic           out_valid_reg;
    logic [BW-1:0]  out_data_reg;
    logic           out_bv_reg;
    logic           out_last_reg;
    logic [CW-1:0]  out_cnt_reg;
    logic [TW-1:0]  out_fill_reg;
    logic [TW-1:0]  out_free_reg;
    logic [TW-1:0]  out_rrun_reg;
    logic [TW-1:0]  out_wrun_reg;

    logic [LW-1:0]  capeff_next;
    logic [CW-1:0]  n_avail;
    logic [CW-1:0]  n_burst;
    logic           n_write;
    logic [CW-1:0]  n_sel;
    logic [SW-1:0]  rp_sum;
    logic [PW-1:0]  rp_adv;
    logic [SW-1:0]  wp_sum;
    logic [PW-1:0]  wp_adv;
    logic [SW-1:0]  bpos_sum;
    logic [PW-1:0]  bpos_adv;
    logic [LW-1:0]  level_after;
    logic [LW-1:0]  free_c;
    logic [LW-1:0]  rspan_c;
    logic [LW-1:0]  wspan_c;
    logic [LW-1:0]  rrun_c;
    logic [LW-1:0]  wrun_c;
    logic           out_free_c;
    logic           pend_move;

    // capacity 0 acts as 1, anything above DEPTH as DEPTH
    always_comb
    begin
        if (cfg_data == '0)
        begin
            capeff_next = LW'(1);
        end
        else if (32'(cfg_data) > 32'(DEPTH))
        begin
            capeff_next = LW'(DEPTH);
        end
        else
        begin
            capeff_next = LW'(cfg_data);
        end
    end

    always_comb
    begin
        if (32'(level_reg) < 32'(len_reg))
        begin
            n_avail = CW'(level_reg);
        end
        else
        begin
            n_avail = CW'(len_reg);
        end
        if (32'(n_avail) > 32'(MAX_BURST))
        begin
            n_burst = CW'(MAX_BURST);
        end
        else
        begin
            n_burst = n_avail;
        end
        n_write = (level_reg < capeff_reg);
        unique case (op_reg)
            brb_pkg::OP_WRITE:   n_sel = CW'(n_write);
            brb_pkg::OP_READ:    n_sel = n_burst;
            brb_pkg::OP_PEEK:    n_sel = n_burst;
            brb_pkg::OP_DISCARD: n_sel = n_avail;
            default:             n_sel = '0;
        endcase
    end

    // pointer + n stays below twice the capacity, one subtract wraps it
    always_comb
    begin
        rp_sum = SW'(rp_reg) + SW'(n_sel);
        if (rp_sum >= SW'(capeff_reg))
        begin
            rp_adv = PW'(rp_sum - SW'(capeff_reg));
        end
        else
        begin
            rp_adv = PW'(rp_sum);
        end
        wp_sum = SW'(wp_reg) + SW'(1);
        if (wp_sum >= SW'(capeff_reg))
        begin
            wp_adv = PW'(wp_sum - SW'(capeff_reg));
        end
        else
        begin
            wp_adv = PW'(wp_sum);
        end
        bpos_sum = SW'(bpos_reg) + SW'(1);
        if (bpos_sum >= SW'(capeff_reg))
        begin
            bpos_adv = PW'(bpos_sum - SW'(capeff_reg));
        end
        else
        begin
            bpos_adv = PW'(bpos_sum);
        end
        level_after = level_reg - LW'(n_sel);
    end

    always_comb
    begin
        free_c  = capeff_reg - level_reg;
        rspan_c = capeff_reg - LW'(rp_reg);
        wspan_c = capeff_reg - LW'(wp_reg);
        rrun_c  = (level_reg < rspan_c) ? level_reg : rspan_c;
        wrun_c  = (free_c < wspan_c) ? free_c : wspan_c;
    end

    assign out_free_c = !out_valid_reg || out_ready;
    assign pend_move  = pend_reg && out_free_c;

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_reg       <= brb_pkg::CFG_W'(DEPTH);
            capeff_reg    <= LW'(DEPTH);
            wp_reg        <= '0;
            rp_reg        <= '0;
            level_reg     <= '0;
            burst_reg     <= 1'b0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                cap_reg    <= cfg_data;
                capeff_reg <= capeff_next;
                wp_reg     <= '0;
                rp_reg     <= '0;
                level_reg  <= '0;
            end
            else if (cmd.exec)
            begin
                burst_reg <= (op_reg == brb_pkg::OP_READ || op_reg == brb_pkg::OP_PEEK)
                             && (n_sel != '0);
                rem_reg   <= n_sel;
                unique case (op_reg)
                    brb_pkg::OP_WRITE:
                    begin
                        if (n_write)
                        begin
                            wp_reg    <= wp_adv;
                            level_reg <= level_reg + LW'(1);
                        end
                    end
                    brb_pkg::OP_READ:
                    begin
                        level_reg <= level_after;
                        // emptied by a read: both pointers restart at zero
                        if (n_sel != '0 && level_after == '0)
                        begin
                            rp_reg <= '0;
                            wp_reg <= '0;
                        end
                        else
                        begin
                            rp_reg <= rp_adv;
                        end
                    end
                    brb_pkg::OP_PEEK:
                    begin
                        level_reg <= level_reg;
                    end
                    brb_pkg::OP_DISCARD:
                    begin
                        rp_reg    <= rp_adv;
                        level_reg <= level_after;
                    end
                    default:
                    begin
                        level_reg <= level_reg;
                    end
                endcase
            end
            else if (cmd.issue)
            begin
                rem_reg <= rem_reg - CW'(1);
            end

            if (cmd.issue)
            begin
                pend_reg <= 1'b1;
            end
            else if (pend_move)
            begin
                pend_reg <= 1'b0;
            end

            if (cmd.single || pend_move)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and store
    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg  <= item_op;
            din_reg <= item_data;
            len_reg <= item_len;
        end
        if (cmd.exec)
        begin
            bpos_reg <= rp_reg;
            cnt_reg  <= n_sel;
            if (op_reg == brb_pkg::OP_WRITE && n_write)
            begin
                mem[wp_reg] <= din_reg;
            end
        end
        if (cmd.stat)
        begin
            fill_st_reg <= level_reg;
            free_st_reg <= free_c;
            rrun_st_reg <= rrun_c;
            wrun_st_reg <= wrun_c;
        end
        if (cmd.issue)
        begin
            rd_data_reg   <= mem[bpos_reg];
            pend_last_reg <= (rem_reg == CW'(1));
            bpos_reg      <= bpos_adv;
        end
        if (cmd.single || pend_move)
        begin
            out_data_reg <= cmd.single ? '0 : rd_data_reg;
            out_bv_reg   <= !cmd.single;
            out_last_reg <= cmd.single ? 1'b1 : pend_last_reg;
            out_cnt_reg  <= cnt_reg;
            out_fill_reg <= TW'(fill_st_reg);
            out_free_reg <= TW'(free_st_reg);
            out_rrun_reg <= TW'(rrun_st_reg);
            out_wrun_reg <= TW'(wrun_st_reg);
        end
    end

    always_comb
    begin
        sts.burst     = burst_reg;
        sts.rem_one   = (rem_reg == CW'(1));
        sts.can_issue = !pend_reg || out_free_c;
        sts.out_free  = out_free_c;
        sts.pend      = pend_reg;
    end

    assign cap            = cap_reg;
    assign out_valid      = out_valid_reg;
    assign out_data       = out_data_reg;
    assign out_byte_valid = out_bv_reg;
    assign out_last       = out_last_reg;
    assign out_count      = out_cnt_reg;
    assign out_fill       = out_fill_reg;
    assign out_free       = out_free_reg;
    assign out_rrun       = out_rrun_reg;
    assign out_wrun       = out_wrun_reg;

endmodule

`default_nettype wire

### verif/brb_checker.sv
// Scoreboard for byte_ring_buffer: follows capacity writes on the APB port and items on
// the s_* stream, predicts every output word and compares it with the m_* stream.
// Depends on brb_pkg.
module brb_checker
    import brb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    input  wire logic              s_tready,
    input  wire logic [15:0]       s_tdata,   // data_in[7:0], length[14:8]
    input  wire logic [OP_W-1:0]   s_tuser,   // op
    input  wire logic              m_tvalid,
    input  wire logic              m_tready,
    input  wire logic [71:0]       m_tdata,   // data_out, count, fill_level,
                                              // free_space, read_run, write_run
    input  wire logic              m_tlast,
    input  wire logic              m_tuser,   // byte_valid
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [APB_W-1:0]  pwdata,
    input  wire logic              pready,
    output int                     mismatches,
    output int                     words_owed
);

    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              valid;
        logic              last;
        logic [CNT_W-1:0]  count;
        logic [STAT_W-1:0] fill;
        logic [STAT_W-1:0] space;
        logic [STAT_W-1:0] rd_run;
        logic [STAT_W-1:0] wr_run;
    } fifo_word_t;

    logic [BYTE_W-1:0] fifo_mem [BRB_DEPTH];
    int unsigned       wr_at;
    int unsigned       rd_at;
    int unsigned       held;
    logic [CFG_W-1:0]  cap_reg;
    fifo_word_t        words_due [$];
    fifo_word_t        seen;

    function automatic int unsigned least(input int unsigned a, input int unsigned b);
        return (a < b) ? a : b;
    endfunction

    // 0 behaves as 1, anything above the store size as the full store
    function automatic int unsigned active_cap();
        if (cap_reg == '0)
            return 1;
        if (cap_reg > BRB_DEPTH)
            return BRB_DEPTH;
        return cap_reg;
    endfunction

    // status fields always reflect the state after the item
    function automatic fifo_word_t status_word(input logic [BYTE_W-1:0] d, input logic v,
                                               input logic l, input int unsigned n);
        fifo_word_t  w;
        int unsigned cap;
        int unsigned room;
        cap      = active_cap();
        room     = cap - held;
        w.data   = d;
        w.valid  = v;
        w.last   = l;
        w.count  = CNT_W'(n);
        w.fill   = STAT_W'(held);
        w.space  = STAT_W'(room);
        w.rd_run = STAT_W'(least(held, cap - rd_at));
        w.wr_run = STAT_W'(least(room, cap - wr_at));
        return w;
    endfunction

    task automatic take_item(input op_t op, input logic [BYTE_W-1:0] din,
                             input logic [LEN_W-1:0] len);
        int unsigned       cap;
        int unsigned       n;
        int unsigned       pos;
        logic [BYTE_W-1:0] burst [BRB_MAX_BURST];
        cap = active_cap();
        case (op)
            OP_WRITE:
            begin
                n = 0;
                if (held < cap)
                begin
                    fifo_mem[wr_at] = din;
                    wr_at = (wr_at + 1) % cap;
                    held++;
                    n = 1;
                end
                words_due.push_back(status_word('0, 1'b0, 1'b1, n));
            end
            OP_DISCARD:
            begin
                // pointers stay where they land, even if this empties the FIFO
                n = least(len, held);
                rd_at = (rd_at + n) % cap;
                held -= n;
                words_due.push_back(status_word('0, 1'b0, 1'b1, n));
            end
            default:
            begin
                n = least(least(len, held), BRB_MAX_BURST);
                if (n == 0)
                    words_due.push_back(status_word('0, 1'b0, 1'b1, 0));
                else
                begin
                    pos = rd_at;
                    for (int i = 0; i < n; i++)
                    begin
                        burst[i] = fifo_mem[pos];
                        pos = (pos + 1) % cap;
                    end
                    if (op == OP_READ)
                    begin
                        held -= n;
                        if (held == 0)
                        begin
                            rd_at = 0;
                            wr_at = 0;
                        end
                        else
                            rd_at = pos;
                    end
                    for (int i = 0; i < n; i++)
                        words_due.push_back(status_word(burst[i], 1'b1, (i + 1 == n), n));
                end
            end
        endcase
    endtask

    task automatic check_word(input fifo_word_t got);
        fifo_word_t want;
        if (words_due.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected word data=%h valid=%b last=%b count=%0d", $realtime,
                         got.data, got.valid, got.last, got.count);
        end
        else
        begin
            want = words_due.pop_front();
            if (got !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: word mismatch (data valid last count fill free rrun wrun)",
                             $realtime);
                    $display("  exp %h %b %b %0d %0d %0d %0d %0d", want.data, want.valid,
                             want.last, want.count, want.fill, want.space, want.rd_run,
                             want.wr_run);
                    $display("  got %h %b %b %0d %0d %0d %0d %0d", got.data, got.valid,
                             got.last, got.count, got.fill, got.space, got.rd_run,
                             got.wr_run);
                end
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_at      = 0;
            rd_at      = 0;
            held       = 0;
            cap_reg    = CFG_W'(BRB_DEPTH);
            mismatches = 0;
            words_due.delete();
            words_owed <= 0;
        end
        else
        begin
            // a capacity write always empties the FIFO
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
            begin
                cap_reg = pwdata[CFG_W-1:0];
                wr_at   = 0;
                rd_at   = 0;
                held    = 0;
            end
            if (s_tvalid && s_tready)
                take_item(op_t'(s_tuser), s_tdata[7:0], s_tdata[14:8]);
            if (m_tvalid && m_tready)
            begin
                seen.data   = m_tdata[7:0];
                seen.valid  = m_tuser;
                seen.last   = m_tlast;
                seen.count  = m_tdata[14:8];
                seen.fill   = m_tdata[27:15];
                seen.space  = m_tdata[40:28];
                seen.rd_run = m_tdata[53:41];
                seen.wr_run = m_tdata[66:54];
                check_word(seen);
            end
            words_owed <= words_due.size();
        end
    end

endmodule

### verif/tb_top.sv
// Testbench top for byte_ring_buffer: drives items, output back-pressure and capacity
// writes over several settings, then reports the verdict.
// Depends on brb_pkg, byte_ring_buffer and brb_checker.
module tb_top;
    import brb_pkg::*;

    localparam int STALL_LIMIT = 1000;

    logic              clk;
    logic              rst_n;
    logic              s_tvalid;
    wire               s_tready;
    logic [15:0]       s_tdata;    // data_in[7:0], length[14:8]
    logic [OP_W-1:0]   s_tuser;    // op
    wire               m_tvalid;
    logic              m_tready;
    wire  [71:0]       m_tdata;    // data_out, count, fill_level,
                                   // free_space, read_run, write_run
    wire               m_tlast;
    wire               m_tuser;    // byte_valid
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [APB_W-1:0]  pwdata;
    wire  [APB_W-1:0]  prdata;
    wire               pready;
    int                mismatches;
    int                words_owed;

    bit tx_gaps = 1'b0;
    bit rx_gaps = 1'b0;
    int items_sent = 0;
    int quiet_cycles = 0;

    byte_ring_buffer dut (.*);
    brb_checker      chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // receiver back-pressure in bursts
    initial
    begin
        int hold;
        hold     = 0;
        m_tready = 1'b1;
        forever
        begin
            @(posedge clk);
            if (hold == 0 && rx_gaps && $urandom_range(0, 7) == 0)
                hold = $urandom_range(1, 19);
            if (hold > 0)
            begin
                m_tready <= 1'b0;
                hold--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else if (quiet_cycles == STALL_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input op_t op, input logic [7:0] data, input logic [6:0] len);
        if (tx_gaps && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, len, data};
        s_tuser  <= op;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        items_sent++;
    endtask

    // words_owed is registered, so look only from the next edge on
    task automatic wait_empty();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (words_owed != 0)
            @(posedge clk);
    endtask

    task automatic start_phase(input logic [CFG_W-1:0] cap, input bit gaps);
        logic [APB_W-1:0] w;
        wait_empty();
        w            = $urandom;
        w[CFG_W-1:0] = cap;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= w;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        tx_gaps = gaps && ($urandom_range(0, 3) != 0);
        rx_gaps = gaps && ($urandom_range(0, 3) != 0);
    endtask

    // mostly a run of writes followed by a few consumers sized near the run,
    // with some fully random items mixed in
    task automatic run_episodes(input int quota, input int max_fill);
        int target;
        int k;
        target = items_sent + quota;
        while (items_sent < target)
        begin
            if ($urandom_range(0, 5) == 0)
                push_item(op_t'($urandom_range(0, 3)), 8'($urandom), 7'($urandom_range(0, 127)));
            else
            begin
                k = $urandom_range(1, max_fill);
                repeat (k)
                    push_item(OP_WRITE, 8'($urandom), 7'($urandom_range(0, 127)));
                repeat ($urandom_range(1, 3))
                    push_item(op_t'($urandom_range(1, 3)), 8'($urandom),
                              ($urandom_range(0, 4) == 0) ? 7'($urandom_range(0, 127))
                                                          : 7'($urandom_range(0, k + 2)));
            end
        end
    endtask

    initial
    begin
        rst_n    = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = OP_WRITE;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // empty FIFO at reset capacity
        push_item(OP_READ, 8'h00, 7'd0);
        push_item(OP_PEEK, 8'h00, 7'd5);
        push_item(OP_DISCARD, 8'hFF, 7'd127);
        push_item(OP_WRITE, 8'h00, 7'd0);
        push_item(OP_WRITE, 8'hFF, 7'd127);
        push_item(OP_WRITE, 8'hA5, 7'd64);
        push_item(OP_PEEK, 8'h00, 7'd0);
        push_item(OP_PEEK, 8'h00, 7'd127);
        push_item(OP_READ, 8'h00, 7'd2);
        // discard past the fill level; read pointer is not rewound
        push_item(OP_DISCARD, 8'h00, 7'd127);
        push_item(OP_WRITE, 8'h5A, 7'd0);
        // read that empties the FIFO rewinds both pointers
        push_item(OP_READ, 8'h00, 7'd1);

        // tiny capacity: full writes and wrap
        start_phase(13'd2, 1'b0);
        push_item(OP_WRITE, 8'h11, 7'd0);
        push_item(OP_WRITE, 8'h22, 7'd0);
        push_item(OP_WRITE, 8'h33, 7'd0);
        push_item(OP_DISCARD, 8'h00, 7'd1);
        push_item(OP_WRITE, 8'h44, 7'd0);
        push_item(OP_PEEK, 8'h00, 7'd64);
        push_item(OP_READ, 8'h00, 7'd65);
        push_item(OP_WRITE, 8'h80, 7'd0);
        push_item(OP_DISCARD, 8'h00, 7'd0);

        start_phase(13'd0, 1'b1);
        run_episodes(4, 3);
        start_phase(13'd5, 1'b1);
        run_episodes(8, 8);

        // above the store size; fill past one burst so reads saturate
        start_phase(13'h1FFF, 1'b1);
        repeat (66)
            push_item(OP_WRITE, 8'($urandom), 7'($urandom_range(0, 127)));
        push_item(OP_READ, 8'h00, 7'd127);
        push_item(OP_PEEK, 8'h00, 7'd100);
        push_item(OP_DISCARD, 8'h00, 7'd127);
        run_episodes(2, 12);

        start_phase(13'd1, 1'b1);
        run_episodes(4, 3);
        start_phase(13'($urandom_range(3, 100)), 1'b1);
        run_episodes(6, 10);

        start_phase(13'd4096, 1'b0);
        run_episodes(4, 6);

        wait_empty();
        repeat (20) @(posedge clk);
        if (mismatches == 0 && words_owed == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

### files.f
hw/rtl/brb_pkg.sv
hw/rtl/brb_ctrl.sv
hw/rtl/brb_datapath.sv
hw/rtl/byte_ring_buffer.sv
verif/brb_checker.sv
verif/tb_top.sv
